>>> sv/ctsi_pkg.sv
// Package with the constants and register indexes of the coolant temperature interlock.
`timescale 1ns / 1ps

package ctsi_pkg;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 22;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_LIMIT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WATER_PRESENT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_PRESENT  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 4'd3;

  localparam logic [6:0]  TEMP_LIMIT_RESET    = 7'd55;
  localparam logic [21:0] SAMPLE_PERIOD_RESET = 22'd450000;

  localparam logic [11:0] WATER_DEFAULT = 12'd1000;
  localparam logic [11:0] WATER_LOW     = 12'd600;
  // floor(x / 5) == (x * 52429) >> 18 for every x below 81920.
  localparam logic [15:0] RECIP_FIVE    = 16'd52429;
  localparam int unsigned RECIP_SHIFT   = 18;

  localparam logic signed [5:0] FAULT_MAX        = 6'sd20;
  localparam logic signed [5:0] FAULT_REARM      = 6'sd12;
  localparam logic signed [5:0] FAULT_INIT       = 6'sd10;
  localparam logic signed [5:0] FAULT_BUZZ_BELOW = 6'sd8;

  localparam logic [3:0] RECOVER_START   = 4'd10;
  localparam logic [1:0] MISS_RESET      = 2'd3;
  localparam logic [1:0] MISS_AFTER_READ = 2'd2;

endpackage

>>> sv/coolant_temp_safety_interlock_unit.sv
// Top level of the coolant flow and temperature safety interlock.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries one timestamped sensor snapshot per
// transaction. A snapshot is evaluated only when more than sample_period_us
// microseconds (32-bit wrapping difference) have passed since the last evaluated one;
// other snapshots are consumed and produce nothing.
// Each evaluated snapshot yields one transaction on the output channel
// (out_valid/out_ready) with the buzzer level, pause and sensor requests, the
// smoothed water level, the held temperature and the fault flag.
// Path: a snapshot accepted on the input channel lands in the input register, is
// evaluated by combinational logic and its result goes into the output register.
// Throughput is one snapshot per cycle while the output register has room; the state
// registers load with the output, so an evaluating snapshot waits only for room.
// When the receiver stalls, the result waits in the output register and the input
// register still retires snapshots that do not evaluate; an evaluating snapshot
// holds in the input register until the output register frees up.
// Configuration writes (cfg_valid/cfg_ready) are always accepted and are
// meant to happen while the block is idle. Synchronous reset restores all
// configuration and state to defaults and empties both registers.
module coolant_temp_safety_interlock_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [31:0]                          in_now_us,
  input  logic [11:0]                          in_water_sample,
  input  logic signed [11:0]                   in_temp_sample,
  input  logic                                 in_temp_ready,
  input  logic                                 in_job_running,
  input  logic                                 in_job_paused,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_buzzer_on,
  output logic                                 out_pause_request,
  output logic                                 out_start_conversion,
  output logic                                 out_restart_sensor,
  output logic [11:0]                          out_water_level,
  output logic signed [11:0]                   out_temperature,
  output logic                                 out_fault_now,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ctsi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ctsi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [6:0]  temp_limit_r;
  logic        water_present_r;
  logic        temp_present_r;
  logic [21:0] period_r;

  // Input register.
  logic               in_valid_r;
  logic [31:0]        now_r;
  logic [11:0]        water_samp_r;
  logic signed [11:0] temp_samp_r;
  logic               temp_rdy_r;
  logic               running_r;
  logic               paused_r;

  // Evaluation state.
  logic [31:0]        last_eval_r;
  logic [11:0]        water_avg_r;
  logic signed [11:0] temp_held_r;
  logic signed [5:0]  fault_count_r;
  logic [3:0]         recover_count_r;
  logic               buzzer_r;
  logic [1:0]         miss_count_r;

  // Output register.
  logic               out_valid_r;
  logic               buzzer_out_r;
  logic               pause_req_r;
  logic               start_conv_r;
  logic               restart_r;
  logic [11:0]        water_out_r;
  logic signed [11:0] temp_out_r;
  logic               fault_out_r;

  // Next values.
  logic [31:0]        elapsed;
  logic               eval;
  logic               retire;
  logic               load_out;
  logic [14:0]        water_sum;
  logic [30:0]        water_prod;
  logic [11:0]        water_avg_nxt;
  logic signed [11:0] temp_held_nxt;
  logic [1:0]         miss_dec;
  logic [1:0]         miss_count_nxt;
  logic               start_conv_nxt;
  logic               restart_nxt;
  logic signed [12:0] temp_ext;
  logic signed [12:0] limit_ext;
  logic               fault_nxt;
  logic signed [5:0]  fc_dec;
  logic signed [5:0]  fault_count_nxt;
  logic [3:0]         rc_dec;
  logic [3:0]         recover_count_nxt;
  logic               buzzer_nxt;
  logic               pause_req_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_limit_r    <= ctsi_pkg::TEMP_LIMIT_RESET;
      water_present_r <= 1'b0;
      temp_present_r  <= 1'b0;
      period_r        <= ctsi_pkg::SAMPLE_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ctsi_pkg::CFG_TEMP_LIMIT:    temp_limit_r    <= cfg_data[6:0];
        ctsi_pkg::CFG_WATER_PRESENT: water_present_r <= cfg_data[0];
        ctsi_pkg::CFG_TEMP_PRESENT:  temp_present_r  <= cfg_data[0];
        ctsi_pkg::CFG_SAMPLE_PERIOD: period_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: a non-evaluating snapshot always retires; an evaluating one needs
  // room in the output register.
  assign elapsed  = now_r - last_eval_r;
  assign eval     = elapsed > {10'd0, period_r};
  assign load_out = in_valid_r && eval && (!out_valid_r || out_ready);
  assign retire   = in_valid_r && (!eval || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || retire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r        <= in_now_us;
      water_samp_r <= in_water_sample;
      temp_samp_r  <= in_temp_sample;
      temp_rdy_r   <= in_temp_ready;
      running_r    <= in_job_running;
      paused_r     <= in_job_paused;
    end
  end

  always_comb begin
    water_sum  = {1'b0, water_avg_r, 2'b00} + {3'd0, water_samp_r};
    water_prod = {16'd0, water_sum} * {15'd0, ctsi_pkg::RECIP_FIVE};
    if (water_present_r) begin
      water_avg_nxt = water_prod[ctsi_pkg::RECIP_SHIFT +: 12];
    end else begin
      water_avg_nxt = ctsi_pkg::WATER_DEFAULT;
    end

    temp_held_nxt  = temp_held_r;
    miss_count_nxt = miss_count_r;
    start_conv_nxt = 1'b0;
    restart_nxt    = 1'b0;
    miss_dec       = miss_count_r - 2'd1;
    if (temp_present_r) begin
      if (temp_rdy_r) begin
        temp_held_nxt  = temp_samp_r;
        miss_count_nxt = ctsi_pkg::MISS_AFTER_READ;
        start_conv_nxt = 1'b1;
      end else if (miss_dec == 2'd0) begin
        miss_count_nxt = ctsi_pkg::MISS_RESET;
        restart_nxt    = 1'b1;
        start_conv_nxt = 1'b1;
      end else begin
        miss_count_nxt = miss_dec;
      end
    end

    temp_ext  = {temp_held_nxt[11], temp_held_nxt};
    limit_ext = {2'b00, temp_limit_r, 4'b0000};
    fault_nxt = (water_avg_nxt < ctsi_pkg::WATER_LOW) || (temp_ext > limit_ext);

    fc_dec            = fault_count_r - 6'sd1;
    rc_dec            = recover_count_r - 4'd1;
    fault_count_nxt   = fault_count_r;
    recover_count_nxt = recover_count_r;
    buzzer_nxt        = buzzer_r;
    pause_req_nxt     = 1'b0;
    if (fault_nxt) begin
      fault_count_nxt = fc_dec;
      if (fc_dec < ctsi_pkg::FAULT_BUZZ_BELOW) begin
        // Minus one has its low bit set, so it buzzes like any odd count.
        buzzer_nxt = fc_dec[0];
        if (fc_dec < 6'sd0) begin
          if (running_r && !paused_r) begin
            pause_req_nxt     = 1'b1;
            recover_count_nxt = ctsi_pkg::RECOVER_START;
          end
          fault_count_nxt = ctsi_pkg::FAULT_REARM;
        end
      end
    end else if (recover_count_r == 4'd0) begin
      buzzer_nxt = 1'b0;
      if (fault_count_r < ctsi_pkg::FAULT_MAX) begin
        fault_count_nxt = fault_count_r + 6'sd1;
      end else begin
        fault_count_nxt = ctsi_pkg::FAULT_MAX;
      end
    end else begin
      buzzer_nxt        = recover_count_r[0];
      recover_count_nxt = (rc_dec < 4'd2) ? 4'd0 : rc_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_eval_r     <= 32'd0;
      water_avg_r     <= ctsi_pkg::WATER_DEFAULT;
      temp_held_r     <= 12'sd0;
      fault_count_r   <= ctsi_pkg::FAULT_INIT;
      recover_count_r <= 4'd0;
      buzzer_r        <= 1'b0;
      miss_count_r    <= ctsi_pkg::MISS_RESET;
    end else if (load_out) begin
      last_eval_r     <= now_r;
      water_avg_r     <= water_avg_nxt;
      temp_held_r     <= temp_held_nxt;
      fault_count_r   <= fault_count_nxt;
      recover_count_r <= recover_count_nxt;
      buzzer_r        <= buzzer_nxt;
      miss_count_r    <= miss_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      buzzer_out_r <= buzzer_nxt;
      pause_req_r  <= pause_req_nxt;
      start_conv_r <= start_conv_nxt;
      restart_r    <= restart_nxt;
      water_out_r  <= water_avg_nxt;
      temp_out_r   <= temp_held_nxt;
      fault_out_r  <= fault_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_buzzer_on        = buzzer_out_r;
  assign out_pause_request    = pause_req_r;
  assign out_start_conversion = start_conv_r;
  assign out_restart_sensor   = restart_r;
  assign out_water_level      = water_out_r;
  assign out_temperature      = temp_out_r;
  assign out_fault_now        = fault_out_r;

`ifndef SYNTHESIS
  a_fault_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_count_r >= 6'sd0) && (fault_count_r <= ctsi_pkg::FAULT_MAX))
    else $error("fault count left its range");

  a_recover_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (recover_count_r != 4'd1) && (recover_count_r <= ctsi_pkg::RECOVER_START))
    else $error("recovery count holds an impossible value");

  a_miss_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    miss_count_r != 2'd0)
    else $error("sensor miss count reached zero");

  a_pause_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pause_req_r) |-> fault_out_r)
    else $error("pause request without a fault");

  a_restart_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && restart_r) |-> start_conv_r)
    else $error("sensor restart without a new conversion");

  a_state_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && (last_eval_r == $past(now_r))))
    else $error("evaluation did not update the timestamp and the result together");
`endif

endmodule
